FILE: rtl/core/bank_switch_mapper_with_rtc_unit_assert.svh
// Assertion macros shared by the bank switch mapper RTL.
`ifndef BANK_SWITCH_MAPPER_WITH_RTC_UNIT_ASSERT_SVH
`define BANK_SWITCH_MAPPER_WITH_RTC_UNIT_ASSERT_SVH

// prop must hold at every clock edge outside reset
`define BSM_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("bsm assertion failed");

// when cond holds, expr must hold at the next clock edge
`define BSM_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error("bsm assertion failed");

`endif

FILE: rtl/core/bsm_pkg.sv
// Package: constants, codes and types of the bank switch mapper.
`timescale 1ns / 1ps
package bsm_pkg;

    localparam int MAX_ROM_BANKS     = 128;
    localparam int RAM_BANKS_DEFAULT = 4;
    localparam int BANK_OFF_W        = 13;
    localparam int RAM_ADDR_W_MAX    = 15;
    localparam int ROM_OFF_W         = 21;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANK_COUNT = 1'b1;

    localparam logic [7:0] ROM_BANK_COUNT_RST = 8'd128;
    localparam logic [2:0] RAM_BANK_COUNT_RST = 3'd4;

    // address regions, address[15:13]
    localparam logic [2:0] REG_RAM_EN  = 3'b000;
    localparam logic [2:0] REG_ROM_BNK = 3'b001;
    localparam logic [2:0] REG_RAM_SEL = 3'b010;
    localparam logic [2:0] REG_LATCH   = 3'b011;
    localparam logic [2:0] REG_EXT_RAM = 3'b101;

    // ram_select codes for the clock registers
    localparam logic [7:0] SEL_RTC_SEC = 8'h08;
    localparam logic [7:0] SEL_RTC_MIN = 8'h09;
    localparam logic [7:0] SEL_RTC_HRS = 8'h0A;
    localparam logic [7:0] SEL_RTC_DL  = 8'h0B;
    localparam logic [7:0] SEL_RTC_DH  = 8'h0C;

    localparam logic [7:0] MASK_SEC = 8'h3F;
    localparam logic [7:0] MASK_MIN = 8'h3F;
    localparam logic [7:0] MASK_HRS = 8'h1F;
    localparam logic [7:0] MASK_DH  = 8'hC1;
    localparam logic [3:0] RAM_EN_KEY = 4'hA;
    localparam logic [6:0] ROM_BANK_MASK = 7'h7F;

    localparam logic [7:0] BYTE_UNMAPPED = 8'hFF;
    localparam logic [7:0] LATCH_ARM     = 8'h00;
    localparam logic [7:0] LATCH_FIRE    = 8'h01;
    localparam logic [7:0] LATCH_IDLE    = 8'hFF;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic        op;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [5:0]  now_seconds;
        logic [5:0]  now_minutes;
        logic [4:0]  now_hours;
        logic [8:0]  now_day;
    } t_item;

    typedef struct packed {
        logic                      we;
        logic                      re;
        logic [RAM_ADDR_W_MAX-1:0] addr;
        logic [7:0]                wdata;
    } t_ram_req;

    typedef struct packed {
        logic                 use_ram;
        logic [7:0]           rd;
        logic                 fetch;
        logic [ROM_OFF_W-1:0] offset;
    } t_result;

endpackage

FILE: rtl/core/bank_switch_mapper_with_rtc_unit.sv
// Top level: bank switch mapper with clock registers, stream in and out.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tuser op; tdata address..now_day
//  m_axis    out  m_axis_tvalid/m_axis_tready    tuser rom_fetch; tdata read_data, rom_offset
//  cfg       in   i_cfg_we                       i_cfg_addr, i_cfg_wdata
//
// One word per cycle sustained while m_axis_tready stays high; an accepted word passes
// through the registered read of the cartridge RAM and then the output register.
// Register and clock state update at the accept edge, so each word sees all earlier ones.
// Reset is synchronous; it clears control state, RAM contents stay undefined.
// A stalled output holds both stages; s_axis_tready drops only when both are full.
`timescale 1ns / 1ps
module bank_switch_mapper_with_rtc_unit #(
    parameter int RAM_BANKS = bsm_pkg::RAM_BANKS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // address[15:0], write_data[23:16], now_seconds[29:24], now_minutes[35:30],
    // now_hours[40:36], now_day[49:41], zero pad [55:50]
    input  logic [55:0]                   s_axis_tdata,
    // op[0]
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // read_data[7:0], rom_offset[28:8], zero pad [31:29]
    output logic [31:0]                   m_axis_tdata,
    // rom_fetch[0]
    output logic                          m_axis_tuser,
    input  logic                          i_cfg_we,
    input  logic [bsm_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [7:0]                    i_cfg_wdata
);

    `include "bank_switch_mapper_with_rtc_unit_assert.svh"

    localparam int RAM_DEPTH = RAM_BANKS * (1 << bsm_pkg::BANK_OFF_W);
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    logic                   w_accept;
    logic                   w_advance;
    bsm_pkg::t_item         w_item;
    bsm_pkg::t_ram_req      w_ram_req;
    bsm_pkg::t_result       w_result;
    logic [7:0]             w_ram_q;

    logic                   r_s1_valid;
    bsm_pkg::t_result       r_s1;
    logic                   r_out_valid;
    logic [7:0]             r_out_rd;
    logic                   r_out_fetch;
    logic [bsm_pkg::ROM_OFF_W-1:0] r_out_offset;

    assign w_item.op          = s_axis_tuser;
    assign w_item.address     = s_axis_tdata[15:0];
    assign w_item.write_data  = s_axis_tdata[23:16];
    assign w_item.now_seconds = s_axis_tdata[29:24];
    assign w_item.now_minutes = s_axis_tdata[35:30];
    assign w_item.now_hours   = s_axis_tdata[40:36];
    assign w_item.now_day     = s_axis_tdata[49:41];

    assign w_advance     = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_advance;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    bsm_ctrl #(
        .RAM_BANKS (RAM_BANKS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_item      (w_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_ram_req   (w_ram_req),
        .o_result    (w_result)
    );

    bsm_ram #(
        .DEPTH  (RAM_DEPTH),
        .ADDR_W (RAM_AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_req.we),
        .i_re    (w_ram_req.re),
        .i_addr  (w_ram_req.addr[RAM_AW-1:0]),
        .i_wdata (w_ram_req.wdata),
        .o_rdata (w_ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_s1_valid <= w_accept;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= w_result;
        end
        if (w_advance) begin
            r_out_rd     <= r_s1.use_ram ? w_ram_q : r_s1.rd;
            r_out_fetch  <= r_s1.fetch;
            r_out_offset <= r_s1.offset;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_fetch;
    assign m_axis_tdata  = {3'd0, r_out_offset, r_out_rd};

    `BSM_ASSERT(a_fetch_no_data, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[7:0] == bsm_pkg::BYTE_UNMAPPED))
    `BSM_ASSERT(a_offset_only_fetch, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[28:8] == '0))
    `BSM_ASSERT_NEXT(a_stage_drains, r_s1_valid && !r_out_valid, r_out_valid)

endmodule

FILE: rtl/core/bsm_ram.sv
// Cartridge RAM: single port, registered read.
`timescale 1ns / 1ps
module bsm_ram #(
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = 15
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [7:0]        i_wdata,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [0:DEPTH-1];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/bsm_ctrl.sv
// Mapper control: bank registers, clock registers, latch and access decode.
`timescale 1ns / 1ps
module bsm_ctrl #(
    parameter int RAM_BANKS = bsm_pkg::RAM_BANKS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  bsm_pkg::t_item                i_item,
    input  logic                          i_cfg_we,
    input  logic [bsm_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [7:0]                    i_cfg_wdata,
    output bsm_pkg::t_ram_req             o_ram_req,
    output bsm_pkg::t_result              o_result
);

    `include "bank_switch_mapper_with_rtc_unit_assert.svh"

    logic [7:0] r_rom_bank_count;
    logic [2:0] r_ram_bank_count;
    logic       r_ram_enable, n_ram_enable;
    logic [6:0] r_rom_bank, n_rom_bank;
    logic [7:0] r_ram_select, n_ram_select;
    logic [7:0] r_last_latch, n_last_latch;
    logic [7:0] r_live [0:4];
    logic [7:0] n_live [0:4];
    logic [7:0] r_latched [0:4];
    logic [7:0] n_latched [0:4];

    logic       w_ram_bank_ok;
    logic       w_rtc_sel;
    logic       w_rom_ok;
    logic       w_latch_fire;
    logic [2:0] w_region;

    always_comb begin
        w_region      = i_item.address[15:13];
        w_ram_bank_ok = (r_ram_select[7:2] == 6'd0)
                     && ({1'b0, r_ram_select[1:0]} < r_ram_bank_count)
                     && (int'(r_ram_select[1:0]) < RAM_BANKS);
        w_rtc_sel     = (r_ram_select >= bsm_pkg::SEL_RTC_SEC)
                     && (r_ram_select <= bsm_pkg::SEL_RTC_DH);
        w_rom_ok      = ({1'b0, r_rom_bank} < r_rom_bank_count)
                     && (int'(r_rom_bank) < bsm_pkg::MAX_ROM_BANKS);
        w_latch_fire  = (r_last_latch == bsm_pkg::LATCH_ARM)
                     && (i_item.write_data == bsm_pkg::LATCH_FIRE);

        n_ram_enable = r_ram_enable;
        n_rom_bank   = r_rom_bank;
        n_ram_select = r_ram_select;
        n_last_latch = r_last_latch;
        n_live       = r_live;
        n_latched    = r_latched;

        o_ram_req.we    = 1'b0;
        o_ram_req.re    = 1'b0;
        o_ram_req.addr  = {r_ram_select[1:0], i_item.address[bsm_pkg::BANK_OFF_W-1:0]};
        o_ram_req.wdata = i_item.write_data;

        o_result.use_ram = 1'b0;
        o_result.rd      = bsm_pkg::BYTE_UNMAPPED;
        o_result.fetch   = 1'b0;
        o_result.offset  = '0;

        if (i_item.op == bsm_pkg::OP_WRITE) begin
            case (w_region)
                bsm_pkg::REG_RAM_EN: begin
                    n_ram_enable = (i_item.write_data[3:0] == bsm_pkg::RAM_EN_KEY);
                end
                bsm_pkg::REG_ROM_BNK: begin
                    n_rom_bank = i_item.write_data[6:0] & bsm_pkg::ROM_BANK_MASK;
                    if (n_rom_bank == 7'd0) begin
                        n_rom_bank = 7'd1;
                    end
                end
                bsm_pkg::REG_RAM_SEL: begin
                    n_ram_select = i_item.write_data;
                end
                bsm_pkg::REG_LATCH: begin
                    if (w_latch_fire) begin
                        n_live[0] = {2'd0, i_item.now_seconds};
                        n_live[1] = {2'd0, i_item.now_minutes};
                        n_live[2] = {3'd0, i_item.now_hours};
                        n_live[3] = i_item.now_day[7:0];
                        n_live[4] = {7'd0, i_item.now_day[8]};
                        n_latched = n_live;
                    end
                    n_last_latch = i_item.write_data;
                end
                bsm_pkg::REG_EXT_RAM: begin
                    if (r_ram_enable) begin
                        if (w_ram_bank_ok) begin
                            o_ram_req.we = i_accept;
                        end
                        case (r_ram_select)
                            bsm_pkg::SEL_RTC_SEC: n_live[0] = i_item.write_data & bsm_pkg::MASK_SEC;
                            bsm_pkg::SEL_RTC_MIN: n_live[1] = i_item.write_data & bsm_pkg::MASK_MIN;
                            bsm_pkg::SEL_RTC_HRS: n_live[2] = i_item.write_data & bsm_pkg::MASK_HRS;
                            bsm_pkg::SEL_RTC_DL:  n_live[3] = i_item.write_data;
                            bsm_pkg::SEL_RTC_DH:  n_live[4] = i_item.write_data & bsm_pkg::MASK_DH;
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end else begin
            if (i_item.address[15:14] == 2'b00) begin
                o_result.fetch  = 1'b1;
                o_result.offset = {7'd0, i_item.address[13:0]};
            end else if (i_item.address[15:14] == 2'b01) begin
                if (w_rom_ok) begin
                    o_result.fetch  = 1'b1;
                    o_result.offset = {r_rom_bank, i_item.address[13:0]};
                end
            end else if ((w_region == bsm_pkg::REG_EXT_RAM) && r_ram_enable) begin
                if (w_ram_bank_ok) begin
                    o_ram_req.re     = i_accept;
                    o_result.use_ram = 1'b1;
                end else if (w_rtc_sel) begin
                    o_result.rd = r_latched[r_ram_select[2:0]];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_bank_count <= bsm_pkg::ROM_BANK_COUNT_RST;
            r_ram_bank_count <= bsm_pkg::RAM_BANK_COUNT_RST;
            r_ram_enable     <= 1'b0;
            r_rom_bank       <= 7'd1;
            r_ram_select     <= 8'd0;
            r_last_latch     <= bsm_pkg::LATCH_IDLE;
            for (int i = 0; i < 5; i++) begin
                r_live[i]    <= 8'd0;
                r_latched[i] <= 8'd0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    bsm_pkg::CFG_ROM_BANK_COUNT: r_rom_bank_count <= i_cfg_wdata;
                    bsm_pkg::CFG_RAM_BANK_COUNT: r_ram_bank_count <= i_cfg_wdata[2:0];
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_ram_enable <= n_ram_enable;
                r_rom_bank   <= n_rom_bank;
                r_ram_select <= n_ram_select;
                r_last_latch <= n_last_latch;
                r_live       <= n_live;
                r_latched    <= n_latched;
            end
        end
    end

    `BSM_ASSERT_NEXT(a_latch_copies, i_accept && (i_item.op == bsm_pkg::OP_WRITE) && (w_region == bsm_pkg::REG_LATCH) && w_latch_fire, r_latched[4] == r_live[4])
    `BSM_ASSERT(a_ram_req_excl, !(o_ram_req.we && o_ram_req.re))

endmodule
